// ===== src/hsp_pkg.sv =====
package hsp_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_MAIN_KNOB    = 3'd0;
    localparam logic [2:0] REG_SYNC_KNOB    = 3'd1;
    localparam logic [2:0] REG_SLEW_STEP    = 3'd2;
    localparam logic [2:0] REG_PHASE_SCALE  = 3'd3;
    localparam logic [2:0] REG_FILTER_ALPHA = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Register reset values
    localparam logic [15:0] MAIN_KNOB_RST    = 16'd32768;
    localparam logic [15:0] SYNC_KNOB_RST    = 16'd32768;
    localparam logic [19:0] SLEW_STEP_RST    = 20'd68;
    localparam logic [23:0] PHASE_SCALE_RST  = 24'd89478;
    localparam logic [15:0] FILTER_ALPHA_RST = 16'd57950;

    // Default phase formats
    localparam int PHASE_FRAC_BITS_DEF     = 32;
    localparam int MAIN_PHASE_INT_BITS_DEF = 8;

    // Voltage and frequency map constants (1 V = 65536, Q16 hertz)
    localparam logic [18:0] VOLTS_5    = 19'd327680;
    localparam logic [27:0] F_MAIN_TOP = 28'd123535360;
    localparam logic [27:0] F_SYNC_TOP = 28'd196608000;
    localparam logic [27:0] K_MAIN     = 28'd353;
    localparam logic [27:0] K_SYNC     = 28'd598;
    localparam int          F_PROD_W   = 52;
    localparam int          F_SHIFT_BASE = 48;

    // Filter and output scaling
    localparam logic signed [53:0] ROUND_ALPHA = 54'sd32768;
    localparam logic signed [53:0] ROUND_OUT   = 54'sd163840;
    localparam logic signed [25:0] PULSE_HIGH  = 26'sd327680;
    localparam logic signed [25:0] PULSE_LOW   = -26'sd327680;
    localparam logic signed [25:0] PREV_MAX    = 26'sd8388607;
    localparam logic signed [25:0] PREV_MIN    = -26'sd8388608;
    localparam logic signed [27:0] Q_MAX       = 28'sd5242879;
    localparam logic signed [27:0] Q_MIN       = -28'sd5242880;
    localparam logic signed [27:0] Q_OFFSET    = 28'sd5242880;
    localparam logic [20:0]        OUT_BIAS    = 21'd1048576;

    // Divide by five: floor(n * DIV5_MUL / 2^26) for n below 2^24
    localparam logic [23:0] DIV5_MUL   = 24'd13421773;
    localparam int          DIV5_SHIFT = 26;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_MAIN  = 3'd0,
        MUL_SYNC  = 3'd1,
        MUL_ALPHA = 3'd2,
        MUL_OUT   = 3'd3,
        MUL_DIVQ  = 3'd4,
        MUL_DIVL  = 3'd5
    } mul_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     slew;
        logic     freq;
        logic     upd_main;
        logic     upd_sync;
        logic     upd_filt;
        logic     upd_q;
        logic     upd_audio;
        logic     upd_led;
        logic     load_out;
        mul_sel_t mul_sel;
    } hsp_cmd_t;

endpackage

// ===== src/hsp_ctrl.sv =====
module hsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output hsp_pkg::hsp_cmd_t cmd
);
    import hsp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SLEW = 13'b0000000000010,
        S_FREQ = 13'b0000000000100,
        S_MULM = 13'b0000000001000,
        S_MULS = 13'b0000000010000,
        S_SYNC = 13'b0000000100000,
        S_FILT = 13'b0000001000000,
        S_MULO = 13'b0000010000000,
        S_DIV  = 13'b0000100000000,
        S_MULQ = 13'b0001000000000,
        S_AUD  = 13'b0010000000000,
        S_LED  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one transaction through the datapath
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_MAIN;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_SLEW;
                end
            end
            S_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = S_FREQ;
            end
            S_FREQ:
            begin
                cmd.freq   = 1'b1;
                state_next = S_MULM;
            end
            S_MULM:
            begin
                cmd.mul_sel = MUL_MAIN;
                state_next  = S_MULS;
            end
            S_MULS:
            begin
                cmd.mul_sel  = MUL_SYNC;
                cmd.upd_main = 1'b1;
                state_next   = S_SYNC;
            end
            S_SYNC:
            begin
                cmd.mul_sel  = MUL_ALPHA;
                cmd.upd_sync = 1'b1;
                state_next   = S_FILT;
            end
            S_FILT:
            begin
                cmd.upd_filt = 1'b1;
                state_next   = S_MULO;
            end
            S_MULO:
            begin
                cmd.mul_sel = MUL_OUT;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.upd_q  = 1'b1;
                state_next = S_MULQ;
            end
            S_MULQ:
            begin
                cmd.mul_sel = MUL_DIVQ;
                state_next  = S_AUD;
            end
            S_AUD:
            begin
                cmd.mul_sel   = MUL_DIVL;
                cmd.upd_audio = 1'b1;
                state_next    = S_LED;
            end
            S_LED:
            begin
                cmd.upd_led = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Raise out_valid when the result is loaded and hold it while the output is stalled
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SLEW))
        else $error("accepted transaction did not start the sequence");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over a waiting result");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");

endmodule

// ===== src/hsp_dp.sv =====
module hsp_dp #(
    parameter int PHASE_FRAC_BITS     = hsp_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAIN_PHASE_INT_BITS = hsp_pkg::MAIN_PHASE_INT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hsp_pkg::hsp_cmd_t                cmd,
    input  logic                             cfg_write,
    input  logic [hsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [20:0]               cv_in,
    output logic signed [20:0]               audio_out,
    output logic [15:0]                      led_level
);
    import hsp_pkg::*;

    localparam int MAIN_W = PHASE_FRAC_BITS + MAIN_PHASE_INT_BITS;
    localparam int SHIFT  = F_SHIFT_BASE - PHASE_FRAC_BITS;
    localparam int INC_W  = F_PROD_W - SHIFT;

    // Configuration registers
    logic [15:0] main_knob_reg, sync_knob_reg, alpha_reg;
    logic [19:0] slew_step_reg;
    logic [23:0] scale_reg;

    // Working state
    logic [18:0]                 cv_reg, slewed_reg;
    logic [27:0]                 fmain_reg, fsync_reg;
    logic [MAIN_W-1:0]           main_phase_reg;
    logic [PHASE_FRAC_BITS-1:0]  sync_phase_reg;
    logic signed [23:0]          prev_reg;
    logic [23:0]                 qoff_reg;
    logic [20:0]                 audio_reg;
    logic [15:0]                 led_reg;
    logic signed [53:0]          prod_reg;
    logic signed [20:0]          audio_out_reg;
    logic [15:0]                 led_out_reg;

    logic [18:0]        cv_clamped, slewed_next, ctrl_main, ctrl_sync;
    logic [27:0]        fmain, fsync;
    logic signed [28:0] mul_a;
    logic signed [24:0] mul_b;
    logic [INC_W-1:0]   inc;
    logic [MAIN_W:0]    main_sum;
    logic [INC_W:0]     sync_sum;
    logic               wrap;
    logic signed [53:0] round_a, round_o;
    logic signed [25:0] pulse, alpha_term, y_full;
    logic signed [23:0] y_sat;
    logic signed [27:0] q_full, q_sat, q_off;
    logic [20:0]        div_q;
    logic [16:0]        div_l;

    function automatic logic [18:0] control_of(input logic [15:0] knob,
                                               input logic [18:0] slewed);
        logic [19:0]        knob10;
        logic signed [21:0] t;
        knob10 = {knob, 3'b000} + {3'b000, knob, 1'b0};
        t = $signed({3'b000, VOLTS_5}) - $signed({2'b00, knob10})
            + $signed({3'b000, slewed});
        if (t < 22'sd0)
            return '0;
        else if (t > $signed({3'b000, VOLTS_5}))
            return VOLTS_5;
        else
            return t[18:0];
    endfunction

    // Clamp the incoming CV to 0..5 V
    always_comb
    begin
        if (cv_in[20])
            cv_clamped = '0;
        else if (cv_in > $signed({2'b00, VOLTS_5}))
            cv_clamped = VOLTS_5;
        else
            cv_clamped = cv_in[18:0];
    end

    // Move the slewed CV toward the clamped CV by at most one step
    always_comb
    begin
        logic signed [21:0] diff, step_s, up, dn;
        diff   = $signed({3'b000, cv_reg}) - $signed({3'b000, slewed_reg});
        step_s = $signed({2'b00, slew_step_reg});
        up     = $signed({3'b000, slewed_reg}) + step_s;
        dn     = $signed({3'b000, slewed_reg}) - step_s;
        priority if (diff > step_s)
            slewed_next = up[18:0];
        else if (diff < -step_s)
            slewed_next = dn[18:0];
        else
            slewed_next = cv_reg;
    end

    // Map controls to frequencies, keep main at or above sync
    assign ctrl_main = control_of(main_knob_reg, slewed_reg);
    assign ctrl_sync = control_of(sync_knob_reg, slewed_reg);
    assign fsync     = F_SYNC_TOP - 28'(ctrl_sync) * K_SYNC;
    always_comb
    begin
        logic [27:0] fm;
        fm    = F_MAIN_TOP - 28'(ctrl_main) * K_MAIN;
        fmain = (fm < fsync) ? fsync : fm;
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_MAIN:
            begin
                mul_a = $signed({1'b0, fmain_reg});
                mul_b = $signed({1'b0, scale_reg});
            end
            MUL_SYNC:
            begin
                mul_a = $signed({1'b0, fsync_reg});
                mul_b = $signed({1'b0, scale_reg});
            end
            MUL_ALPHA:
            begin
                mul_a = $signed({13'd0, alpha_reg});
                mul_b = $signed({prev_reg[23], prev_reg});
            end
            MUL_OUT:
            begin
                mul_a = $signed({{5{prev_reg[23]}}, prev_reg});
                mul_b = $signed({6'd0, cv_reg});
            end
            MUL_DIVQ:
            begin
                mul_a = $signed({5'd0, qoff_reg});
                mul_b = $signed({1'b0, DIV5_MUL});
            end
            MUL_DIVL:
            begin
                mul_a = $signed({9'd0, 20'(cv_reg) + 20'd2});
                mul_b = $signed({1'b0, DIV5_MUL});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Phase increments and accumulator sums
    assign inc      = prod_reg[SHIFT +: INC_W];
    assign main_sum = {1'b0, main_phase_reg} + (MAIN_W + 1)'(inc);
    assign sync_sum = (INC_W + 1)'(sync_phase_reg) + {1'b0, inc};
    assign wrap     = |sync_sum[INC_W:PHASE_FRAC_BITS];

    // Pulse and leaky filter
    assign pulse      = (main_phase_reg[MAIN_W-1:PHASE_FRAC_BITS-1] == '0)
                        ? PULSE_HIGH : PULSE_LOW;
    assign round_a    = prod_reg + ROUND_ALPHA;
    assign alpha_term = round_a[41:16];
    assign y_full     = pulse - $signed({{2{prev_reg[23]}}, prev_reg}) + alpha_term;
    always_comb
    begin
        if (y_full > PREV_MAX)
            y_sat = PREV_MAX[23:0];
        else if (y_full < PREV_MIN)
            y_sat = PREV_MIN[23:0];
        else
            y_sat = y_full[23:0];
    end

    // Output scaling: divide by 65536 here, by five in later steps
    assign round_o = prod_reg + ROUND_OUT;
    assign q_full  = round_o[43:16];
    always_comb
    begin
        if (q_full > Q_MAX)
            q_sat = Q_MAX;
        else if (q_full < Q_MIN)
            q_sat = Q_MIN;
        else
            q_sat = q_full;
    end
    assign q_off = q_sat + Q_OFFSET;
    assign div_q = prod_reg[DIV5_SHIFT +: 21];
    assign div_l = prod_reg[DIV5_SHIFT +: 17];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_knob_reg <= MAIN_KNOB_RST;
            sync_knob_reg <= SYNC_KNOB_RST;
            slew_step_reg <= SLEW_STEP_RST;
            scale_reg     <= PHASE_SCALE_RST;
            alpha_reg     <= FILTER_ALPHA_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAIN_KNOB:    main_knob_reg <= cfg_data[15:0];
                REG_SYNC_KNOB:    sync_knob_reg <= cfg_data[15:0];
                REG_SLEW_STEP:    slew_step_reg <= cfg_data[19:0];
                REG_PHASE_SCALE:  scale_reg     <= cfg_data;
                REG_FILTER_ALPHA: alpha_reg     <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slewed_reg     <= '0;
            main_phase_reg <= '0;
            sync_phase_reg <= '0;
            prev_reg       <= '0;
        end
        else
        begin
            if (cmd.slew)
                slewed_reg <= slewed_next;
            if (cmd.upd_main)
                main_phase_reg <= main_sum[MAIN_W] ? '1 : main_sum[MAIN_W-1:0];
            if (cmd.upd_sync)
            begin
                sync_phase_reg <= sync_sum[PHASE_FRAC_BITS-1:0];
                if (wrap)
                    main_phase_reg <= '0;
            end
            if (cmd.upd_filt)
                prev_reg <= y_sat;
        end
    end

    // Working registers and multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load_in)
            cv_reg <= cv_clamped;
        if (cmd.freq)
        begin
            fmain_reg <= fmain;
            fsync_reg <= fsync;
        end
        if (cmd.upd_q)
            qoff_reg <= q_off[23:0];
        if (cmd.upd_audio)
            audio_reg <= div_q - OUT_BIAS;
        if (cmd.upd_led)
            led_reg <= div_l[16] ? 16'hFFFF : div_l[15:0];
        if (cmd.load_out)
        begin
            audio_out_reg <= $signed(audio_reg);
            led_out_reg   <= led_reg;
        end
    end

    assign audio_out = audio_out_reg;
    assign led_level = led_out_reg;

    a_slew_range: assert property (@(posedge clk) disable iff (!rst_n)
        slewed_reg <= VOLTS_5)
        else $error("slewed CV left the 0..5 V range");

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.upd_sync && wrap) |=> (main_phase_reg == '0))
        else $error("sync wrap did not clear the main phase");

endmodule

// ===== src/hard_sync_pulse_voice.sv =====
// Hard-synced pulse voice. One CV sample (cv_in, 65536 per volt) is taken per
// transaction and gives exactly one result: audio_out, a filtered +/-5 V pulse
// scaled by the clamped CV, and led_level, the clamped CV times 0.2 in Q16.
// A controller steps each transaction through its states in order (slew,
// freq, main and sync multiply, sync, filter, output multiply, divide,
// quotient multiply, audio, LED, done) and drives one shared multiplier
// through six products (two phase increments, the filter leak, the output
// scale and two divisions by five). in_stall is high while a transaction is
// in work, so a new sample is accepted only in idle; a finished result waits
// in the output register while the next sample is accepted, and a new result
// waits in the final step until the previous one has been taken.
// Configuration (cfg_index 0..4: main_knob, sync_knob, slew_step, phase_scale,
// filter_alpha) is always ready and should be written while idle.
module hard_sync_pulse_voice #(
    parameter int PHASE_FRAC_BITS     = hsp_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAIN_PHASE_INT_BITS = hsp_pkg::MAIN_PHASE_INT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [20:0]               cv_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [20:0]               audio_out,
    output logic [15:0]                      led_level,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsp_pkg::*;

    hsp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequence control
    hsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Arithmetic and state
    hsp_dp #(
        .PHASE_FRAC_BITS     (PHASE_FRAC_BITS),
        .MAIN_PHASE_INT_BITS (MAIN_PHASE_INT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cv_in     (cv_in),
        .audio_out (audio_out),
        .led_level (led_level)
    );

endmodule
